@@ hdl/tksm_pkg.sv @@
// Shared types and constants for the trie keyword stream matcher.
`timescale 1ns / 1ps

package tksm_pkg;

    // Field widths fixed by the item format.
    localparam int SYM_W = 8;
    localparam int ID_W  = 6;

    // Request kind carried in the input tuser bit.
    typedef enum logic {
        CMD_SCAN   = 1'b0,
        CMD_INSERT = 1'b1
    } t_cmd;

    // One entry of the node tag memory.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } t_tag;

    // Result request as it appears on the output tdata, lowest bit last here.
    typedef struct packed {
        logic            table_full;
        logic [ID_W-1:0] match_id;
        logic            match_found;
    } t_result;

endpackage

@@ hdl/tksm_ram.sv @@
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module tksm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]                      o_rdata_a,
    input  logic                                  i_re_b,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                      o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read at the written address returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

@@ hdl/trie_keyword_stream_matcher.sv @@
// Top level of the trie keyword stream matcher.
`timescale 1ns / 1ps

// Multi-keyword matcher over a byte stream, with the trie held as a
// node-by-byte transition table in RAM and a node tag RAM.
// Input channel s_axis: tuser = command (0 scan a byte, 1 insert a pattern
// byte), tdata = symbol and pattern id, tlast = final byte of a pattern.
// Output channel m_axis: one result request per input request, tdata =
// match found, match id, table full.
// The table read made at acceptance is registered, and the cursor for the
// next request is only known once that read returns, so the input takes no
// new request while one sits in stage B.
// A result passes through stage B (table read), stage C (tag RAM read for
// scans) and then the output register.
// A two-entry output queue lets the input keep accepting while one result
// waits; with both entries full, or one full and one in flight, the input
// stalls until the receiver drains the queue.
// Reset (i_rst_n low, synchronous) returns both cursors to the root and
// starts a clearing pass over every entry of the transition table; the tag
// RAM is cleared in the same pass. No request is accepted until the pass
// is done.
module trie_keyword_stream_matcher #(
    parameter int NODE_COUNT    = 256,
    parameter int PATTERN_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // symbol[7:0], pattern_id[13:8], zero[15:14]
    input  logic        s_axis_tlast,   // end_of_pattern
    input  logic [0:0]  s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // match_found[0], match_id[6:1], table_full[7]
);

    localparam int NW        = $clog2(NODE_COUNT);
    localparam int TAW       = NW + tksm_pkg::SYM_W;
    localparam int TBL_DEPTH = NODE_COUNT * 256;
    localparam int TAG_W     = $bits(tksm_pkg::t_tag);

    // Clearing pass state.
    logic           r_clearing;
    logic [TAW-1:0] r_clr_addr;

    // Trie cursors and allocator.
    logic [NW-1:0]  r_scan_cur;
    logic [NW-1:0]  r_load_cur;
    logic [NW:0]    r_next_free;

    // Stage B: table read data is back.
    logic                       r_b_valid;
    tksm_pkg::t_cmd             r_b_cmd;
    logic [tksm_pkg::SYM_W-1:0] r_b_sym;
    logic [tksm_pkg::ID_W-1:0]  r_b_pid;
    logic                       r_b_eop;
    logic [NW-1:0]              r_b_cur;

    // Stage C: tag read data is back.
    logic r_c_valid;
    logic r_c_scan;
    logic r_c_nz;
    logic r_c_full;

    // Output queue.
    logic              r_out_valid;
    tksm_pkg::t_result r_out;
    logic              r_skid_valid;
    tksm_pkg::t_result r_skid;

    // Memory ports.
    logic [NW-1:0]   w_rd_a;
    logic [NW-1:0]   w_rd_b;
    logic [TAW-1:0]  w_raddr_a;
    logic [TAW-1:0]  w_raddr_b;
    logic            w_tbl_we;
    logic [TAW-1:0]  w_tbl_waddr;
    logic [NW-1:0]   w_tbl_wdata;
    logic            w_tag_we;
    logic [NW-1:0]   w_tag_waddr;
    tksm_pkg::t_tag  w_tag_wdata;
    tksm_pkg::t_tag  w_tag_rd;

    // Request decode and stage logic.
    logic                       w_accept;
    tksm_pkg::t_cmd             w_in_cmd;
    logic [tksm_pkg::SYM_W-1:0] w_in_sym;
    logic [1:0]                 w_pending;
    logic                       w_hit;
    logic                       w_alloc_full;
    logic                       w_ins_full;
    logic                       w_ins_write;
    logic                       w_tag_write;
    logic                       w_pid_ok;
    logic [NW-1:0]              w_scan_nxt;
    logic [NW-1:0]              w_ins_nxt;
    logic                       w_pop;
    tksm_pkg::t_result          w_res;

    // Input handshake: one request in stage B at a time, and room for its result.
    assign w_in_cmd  = tksm_pkg::t_cmd'(s_axis_tuser[0]);
    assign w_in_sym  = s_axis_tdata[7:0];
    assign w_pending = {1'b0, r_c_valid} + {1'b0, r_out_valid} + {1'b0, r_skid_valid};
    assign s_axis_tready = !r_clearing && !r_b_valid && (w_pending < 2'd2);
    assign w_accept  = s_axis_tvalid && s_axis_tready;

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == TAW'(TBL_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Table reads: port A at the cursor's edge, port B at the root's edge.
    assign w_raddr_a = {(w_in_cmd == tksm_pkg::CMD_INSERT) ? r_load_cur : r_scan_cur, w_in_sym};
    assign w_raddr_b = {NW'(0), w_in_sym};

    // Stage B next-node decisions.
    assign w_hit        = (w_rd_a != '0);
    assign w_alloc_full = (r_next_free == (NW + 1)'(NODE_COUNT));
    assign w_scan_nxt   = w_hit ? w_rd_a : w_rd_b;
    assign w_ins_nxt    = w_hit ? w_rd_a : r_next_free[NW-1:0];
    assign w_ins_full   = !w_hit && w_alloc_full;
    assign w_pid_ok     = (int'(r_b_pid) < PATTERN_COUNT);
    assign w_ins_write  = r_b_valid && (r_b_cmd == tksm_pkg::CMD_INSERT)
                          && !w_hit && !w_alloc_full;
    assign w_tag_write  = r_b_valid && (r_b_cmd == tksm_pkg::CMD_INSERT)
                          && !w_ins_full && r_b_eop && w_pid_ok;

    // Table write: zero during clearing, new edge on insert.
    assign w_tbl_we    = r_clearing || w_ins_write;
    assign w_tbl_waddr = r_clearing ? r_clr_addr : {r_b_cur, r_b_sym};
    assign w_tbl_wdata = r_clearing ? '0 : r_next_free[NW-1:0];

    // Tag write: untag each node once during clearing, tag on a pattern end.
    assign w_tag_we          = (r_clearing && (r_clr_addr[7:0] == 8'd0)) || w_tag_write;
    assign w_tag_waddr       = r_clearing ? r_clr_addr[TAW-1:8] : w_ins_nxt;
    assign w_tag_wdata.valid = !r_clearing;
    assign w_tag_wdata.id    = r_clearing ? '0 : r_b_pid;

    tksm_ram #(
        .WIDTH (NW),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_tbl_we),
        .i_waddr   (w_tbl_waddr),
        .i_wdata   (w_tbl_wdata),
        .i_re_a    (w_accept),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rd_a),
        .i_re_b    (w_accept),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rd_b)
    );

    tksm_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NODE_COUNT)
    ) u_tags (
        .i_clk     (i_clk),
        .i_we      (w_tag_we),
        .i_waddr   (w_tag_waddr),
        .i_wdata   (w_tag_wdata),
        .i_re_a    (r_b_valid && (r_b_cmd == tksm_pkg::CMD_SCAN)),
        .i_raddr_a (w_scan_nxt),
        .o_rdata_a (w_tag_rd),
        .i_re_b    (1'b0),
        .i_raddr_b (w_scan_nxt),
        .o_rdata_b ()
    );

    // Stage B payload capture at acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_cmd <= w_in_cmd;
            r_b_sym <= w_in_sym;
            r_b_pid <= s_axis_tdata[13:8];
            r_b_eop <= s_axis_tlast;
            r_b_cur <= r_load_cur;
        end
    end

    // Cursor, allocator and stage valid updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_scan_cur  <= '0;
            r_load_cur  <= '0;
            r_next_free <= (NW + 1)'(1);
        end else begin
            r_b_valid <= w_accept;
            r_c_valid <= r_b_valid;
            if (r_b_valid) begin
                if (r_b_cmd == tksm_pkg::CMD_SCAN) begin
                    r_scan_cur <= w_scan_nxt;
                end else if (w_ins_full || r_b_eop) begin
                    r_load_cur <= '0;
                end else begin
                    r_load_cur <= w_ins_nxt;
                end
            end
            if (w_ins_write) begin
                r_next_free <= r_next_free + 1'b1;
            end
        end
    end

    // Stage C payload.
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_scan <= (r_b_cmd == tksm_pkg::CMD_SCAN);
            r_c_nz   <= (w_scan_nxt != '0);
            r_c_full <= (r_b_cmd == tksm_pkg::CMD_INSERT) && w_ins_full;
        end
    end

    // Result formation from the tag read.
    assign w_res.match_found = r_c_scan && r_c_nz && w_tag_rd.valid;
    assign w_res.match_id    = w_res.match_found ? w_tag_rd.id : '0;
    assign w_res.table_full  = r_c_full;

    // Two-entry output queue.
    assign w_pop = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= r_c_valid;
                r_skid       <= w_res;
            end else begin
                r_out_valid <= r_c_valid;
                r_out       <= w_res;
            end
        end else if (r_c_valid) begin
            r_skid_valid <= 1'b1;
            r_skid       <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef ASSERT_OFF
    // No request enters while the clearing pass runs.
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    // The cursor update interlock: no acceptance while stage B is busy.
    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> !w_accept)
        else $error("request accepted while cursor update pending");

    // The output queue never drops a result.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_out_valid && r_skid_valid) |-> w_pop)
        else $error("output queue overflow");

    // The allocator never passes the node count.
    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_next_free) <= NODE_COUNT)
        else $error("node allocator out of range");

    // Cursors always name an existing node.
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_scan_cur) < int'(r_next_free)) && (int'(r_load_cur) < int'(r_next_free)))
        else $error("cursor points past allocated nodes");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the trie keyword stream matcher.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD   = 4;
    localparam int NODES        = 256;
    localparam int RANDOM_REQS  = 2000;
    // Covers the table clearing pass after reset and the stalled stream many times over.
    localparam int LIMIT_CYCLES = 600000;

    // One input request as queued for the driver.
    typedef struct packed {
        logic                       drain_first;
        tksm_pkg::t_cmd             cmd;
        logic [tksm_pkg::SYM_W-1:0] symbol;
        logic [tksm_pkg::ID_W-1:0]  pattern_id;
        logic                       last_byte;
    } t_req;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // symbol[7:0], pattern_id[13:8], zero[15:14]
    logic        s_axis_tlast = 1'b0; // end_of_pattern
    logic [0:0]  s_axis_tuser = '0;   // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // match_found[0], match_id[6:1], table_full[7]

    trie_keyword_stream_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Stimulus and scoreboard storage.
    t_req              stream_reqs[$];
    tksm_pkg::t_result match_results_due[$];
    int                req_total;
    int                reqs_sent;
    int                reqs_accepted;
    int                results_seen;
    int                error_count;
    bit                req_taken;
    bit                hold_next;

    // Predicted trie contents and cursors.
    bit [7:0]                trie_next [NODES][256];
    bit                      tag_set [NODES];
    bit [tksm_pkg::ID_W-1:0] tag_pid [NODES];
    bit [7:0]                scan_node;
    bit [7:0]                load_node;
    int                      free_node = 1;

    // Library of completed patterns, reused to build matching scan streams.
    bit [7:0] lib_bytes [64][6];
    int       lib_len [64];
    int       lib_count;

    // Advances the predicted trie by one request and returns the result it gives.
    function automatic tksm_pkg::t_result trie_step(tksm_pkg::t_cmd cmd, logic [7:0] sym,
                                                    logic [tksm_pkg::ID_W-1:0] pid,
                                                    logic last_byte);
        tksm_pkg::t_result res;
        bit [7:0]          node;
        res = '0;
        if (cmd == tksm_pkg::CMD_SCAN) begin
            // Follow the edge, fall back to the root's edge, else land on the root.
            node = trie_next[scan_node][sym];
            if (node == 0) begin
                node = trie_next[0][sym];
            end
            scan_node = node;
            if (node != 0 && tag_set[node]) begin
                res.match_found = 1'b1;
                res.match_id    = tag_pid[node];
            end
        end else begin
            node = trie_next[load_node][sym];
            if (node == 0 && free_node >= NODES) begin
                // No node left: flag it and restart the pattern from the root.
                res.table_full = 1'b1;
                load_node      = 0;
            end else begin
                if (node == 0) begin
                    node = free_node[7:0];
                    trie_next[load_node][sym] = node;
                    free_node++;
                end
                // A 6-bit id is always below the pattern count, so the tag is always written.
                if (last_byte) begin
                    tag_set[node] = 1'b1;
                    tag_pid[node] = pid;
                    load_node     = 0;
                end else begin
                    load_node = node;
                end
            end
        end
        return res;
    endfunction

    task automatic add_req(input tksm_pkg::t_cmd cmd, input logic [7:0] sym,
                           input logic [tksm_pkg::ID_W-1:0] pid, input logic last_byte);
        t_req r;
        r.drain_first = hold_next;
        r.cmd         = cmd;
        r.symbol      = sym;
        r.pattern_id  = pid;
        r.last_byte   = last_byte;
        hold_next     = 1'b0;
        stream_reqs.push_back(r);
    endtask

    // Half the symbols come from a small alphabet so that patterns share prefixes.
    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(0, 1) == 1) begin
            return 8'h61 + 8'($urandom_range(0, 7));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_scan(input logic [7:0] sym);
        add_req(tksm_pkg::CMD_SCAN, sym, tksm_pkg::ID_W'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)));
    endtask

    // Inserts a random pattern; a few are left without their final byte marker.
    task automatic add_random_pattern();
        int                        len;
        int                        slot;
        bit                        broken;
        logic [tksm_pkg::ID_W-1:0] pid;
        logic [7:0]                sym;
        len    = $urandom_range(1, 6);
        broken = ($urandom_range(0, 99) < 10);
        pid    = tksm_pkg::ID_W'($urandom_range(0, 63));
        slot   = lib_count % 64;
        for (int i = 0; i < len; i++) begin
            sym = pick_symbol();
            lib_bytes[slot][i] = sym;
            add_req(tksm_pkg::CMD_INSERT, sym, pid, (i == len - 1) && !broken);
        end
        if (!broken) begin
            lib_len[slot] = len;
            lib_count++;
        end
    endtask

    // Scan stream built from stored patterns mixed with noise bytes.
    task automatic add_random_scan_stream();
        int segs;
        int k;
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++) begin
            if (lib_count > 0 && $urandom_range(0, 99) < 60) begin
                k = $urandom_range(0, ((lib_count < 64) ? lib_count : 64) - 1);
                for (int i = 0; i < lib_len[k]; i++) begin
                    add_scan(lib_bytes[k][i]);
                end
            end else begin
                repeat ($urandom_range(1, 3)) add_scan(pick_symbol());
            end
        end
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int directed;
        int r;
        // Directed requests: empty-trie scan, extreme symbols and ids, shared
        // prefixes, retagging, existing edges and the root fallback.
        add_req(tksm_pkg::CMD_SCAN,   8'h00, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_INSERT, 8'h00, 6'd0,  1'b1);
        add_req(tksm_pkg::CMD_INSERT, 8'hFF, 6'd63, 1'b0);
        add_req(tksm_pkg::CMD_INSERT, 8'h80, 6'd63, 1'b1);
        add_req(tksm_pkg::CMD_INSERT, 8'hFF, 6'd5,  1'b1);
        add_req(tksm_pkg::CMD_INSERT, 8'hFF, 6'd42, 1'b1);
        add_req(tksm_pkg::CMD_INSERT, 8'h41, 6'd1,  1'b0);
        add_req(tksm_pkg::CMD_INSERT, 8'h42, 6'd1,  1'b1);
        add_req(tksm_pkg::CMD_SCAN,   8'h00, 6'd63, 1'b1);
        add_req(tksm_pkg::CMD_SCAN,   8'hFF, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'h80, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'h42, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'h41, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'h42, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'hFF, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'h41, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'h42, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_INSERT, 8'hFF, 6'd7,  1'b0);
        add_req(tksm_pkg::CMD_INSERT, 8'h80, 6'd7,  1'b1);
        add_req(tksm_pkg::CMD_SCAN,   8'hFF, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'h80, 6'd0,  1'b0);
        add_req(tksm_pkg::CMD_SCAN,   8'h7E, 6'd0,  1'b0);
        directed = stream_reqs.size();

        // Random part: the driver waits for the directed results to drain first.
        hold_next = 1'b1;
        while (stream_reqs.size() < directed + RANDOM_REQS) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                add_random_pattern();
            end else if (r < 88) begin
                add_random_scan_stream();
            end else begin
                add_req(tksm_pkg::t_cmd'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        tksm_pkg::ID_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
        end
        req_total = stream_reqs.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (reqs_accepted < req_total || match_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Request driver: idles by phase, and holds a marked request until the block is drained.
    always @(negedge i_clk) begin : drive_requests
        t_req nxt;
        int   idle_pct;
        if (reqs_sent < req_total / 3) begin
            idle_pct = 25;
        end else if (reqs_sent < 2 * req_total / 3) begin
            idle_pct = 59;
        end else begin
            idle_pct = 0;
        end
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (stream_reqs.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (stream_reqs[0].drain_first && match_results_due.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                nxt = stream_reqs.pop_front();
                reqs_sent++;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, nxt.pattern_id, nxt.symbol};
                s_axis_tlast  <= nxt.last_byte;
                s_axis_tuser  <= nxt.cmd;
            end
        end
    end

    // Result receiver: stalls by phase.
    always @(negedge i_clk) begin : drive_ready
        int stall_pct;
        if (results_seen < req_total / 3) begin
            stall_pct = 59;
        end else if (results_seen < 2 * req_total / 3) begin
            stall_pct = 25;
        end else begin
            stall_pct = 0;
        end
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge i_clk) begin : watch_streams
        tksm_pkg::t_result got;
        tksm_pkg::t_result want;
        req_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            match_results_due.push_back(trie_step(tksm_pkg::t_cmd'(s_axis_tuser[0]),
                                                  s_axis_tdata[7:0],
                                                  s_axis_tdata[13:8],
                                                  s_axis_tlast));
            reqs_accepted++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = tksm_pkg::t_result'(m_axis_tdata);
            results_seen++;
            if (match_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want = match_results_due.pop_front();
                if (got.match_found !== want.match_found) begin
                    $display("%0t: match_found expected %0d actual %0d",
                             $time, want.match_found, got.match_found);
                    error_count++;
                end
                if (got.match_id !== want.match_id) begin
                    $display("%0t: match_id expected %0d actual %0d",
                             $time, want.match_id, got.match_id);
                    error_count++;
                end
                if (got.table_full !== want.table_full) begin
                    $display("%0t: table_full expected %0d actual %0d",
                             $time, want.table_full, got.table_full);
                    error_count++;
                end
            end
        end
    end

endmodule

@@ files.f @@
hdl/tksm_pkg.sv
hdl/tksm_ram.sv
hdl/trie_keyword_stream_matcher.sv
tb/sv/tb_top.sv
